// File: design/assert_macros.svh
// assertion helpers for the ramp controller
// all checks run on clk and are off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define PRSR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PRSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/prsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsr_pkg
// types, constants and helpers shared by the pwm ramp controller
// ----------------------------------------------------------------------------
`default_nettype none

package prsr_pkg;

	localparam int DUTY_W = 10;
	localparam int TICK_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [DUTY_W-1:0] DUTY_MAX = 10'd1023;

	// register reset values
	localparam logic [DUTY_W-1:0] RAMP_STEP_RST = 10'd20;
	localparam logic [DUTY_W-1:0] DOWN_STEP_RST = 10'd15;
	localparam logic [DUTY_W-1:0] UP_STEP_RST = 10'd5;
	localparam logic [TICK_W-1:0] REV_TIMEOUT_RST = 16'd100;
	localparam logic [TICK_W-1:0] REV_HOLD_RST = 16'd200;
	localparam logic [TICK_W-1:0] WATCHDOG_RST = 16'd12000;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RAMP_STEP   = 3'd0,
		REG_DOWN_STEP   = 3'd1,
		REG_UP_STEP     = 3'd2,
		REG_REV_TIMEOUT = 3'd3,
		REG_REV_HOLD    = 3'd4,
		REG_WATCHDOG    = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_SET   = 2'd1,
		OP_REV   = 2'd2,
		OP_BRAKE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_DOWN = 2'd1,
		PH_HOLD = 2'd2
	} phase_t;

	typedef struct packed {
		logic [DUTY_W-1:0] ramp_step;
		logic [DUTY_W-1:0] down_step;
		logic [DUTY_W-1:0] up_step;
		logic [TICK_W-1:0] rev_timeout;
		logic [TICK_W-1:0] rev_hold;
		logic [TICK_W-1:0] watchdog;
	} cfg_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic [DUTY_W-1:0] goal;
		logic              dir;
		logic [DUTY_W-1:0] step;
		logic [TICK_W-1:0] ticks;
		phase_t            phase;
		logic [TICK_W-1:0] phase_start;
		logic              pend_dir;
		logic [DUTY_W-1:0] pend_goal;
	} state_t;

	// negative requests give zero, large ones saturate at full duty
	function automatic logic [DUTY_W-1:0] clamp_target(input logic signed [15:0] raw);
		logic [DUTY_W-1:0] res;
		if (raw[15]) begin
			res = '0;
		end else if (raw[14:0] > 15'(DUTY_MAX)) begin
			res = DUTY_MAX;
		end else begin
			res = raw[DUTY_W-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// File: design/prsr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsr_cfg_regs
// configuration register file, flags a ramp step write for the step reload
// ----------------------------------------------------------------------------
`default_nettype none

module prsr_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [prsr_pkg::CFG_IDX_W-1:0]      wr_idx,
	input  wire logic [prsr_pkg::CFG_DATA_W-1:0]     wr_data,
	output prsr_pkg::cfg_t                           cfg,
	output logic                                     ramp_load
);

	prsr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_step   <= prsr_pkg::RAMP_STEP_RST;
			cfg_q.down_step   <= prsr_pkg::DOWN_STEP_RST;
			cfg_q.up_step     <= prsr_pkg::UP_STEP_RST;
			cfg_q.rev_timeout <= prsr_pkg::REV_TIMEOUT_RST;
			cfg_q.rev_hold    <= prsr_pkg::REV_HOLD_RST;
			cfg_q.watchdog    <= prsr_pkg::WATCHDOG_RST;
		end else if (wr_en) begin
			unique case (wr_idx)
				prsr_pkg::REG_RAMP_STEP:   cfg_q.ramp_step   <= wr_data[prsr_pkg::DUTY_W-1:0];
				prsr_pkg::REG_DOWN_STEP:   cfg_q.down_step   <= wr_data[prsr_pkg::DUTY_W-1:0];
				prsr_pkg::REG_UP_STEP:     cfg_q.up_step     <= wr_data[prsr_pkg::DUTY_W-1:0];
				prsr_pkg::REG_REV_TIMEOUT: cfg_q.rev_timeout <= wr_data;
				prsr_pkg::REG_REV_HOLD:    cfg_q.rev_hold    <= wr_data;
				prsr_pkg::REG_WATCHDOG:    cfg_q.watchdog    <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
	assign ramp_load = wr_en && (wr_idx == prsr_pkg::REG_RAMP_STEP);

endmodule

`default_nettype wire

// File: design/prsr_step_logic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsr_step_logic
// next controller state for one request: ramp, tick counter, watchdog, reversal
// ----------------------------------------------------------------------------
`default_nettype none

module prsr_step_logic (
	input  prsr_pkg::state_t                st,
	input  prsr_pkg::cfg_t                  cfg,
	input  wire logic [1:0]                 opcode,
	input  wire logic                       direction,
	input  wire logic signed [15:0]         target_pwm,
	output prsr_pkg::state_t                nx
);

	logic [prsr_pkg::DUTY_W:0]   up_sum;
	logic [prsr_pkg::DUTY_W-1:0] down_gap;
	logic [prsr_pkg::TICK_W-1:0] waited;
	logic [prsr_pkg::TICK_W-1:0] held;
	logic                        advance;
	logic                        idle;

	always_comb begin
		nx       = st;
		advance  = 1'b0;
		idle     = (st.phase == prsr_pkg::PH_IDLE);
		up_sum   = {1'b0, st.duty} + {1'b0, st.step};
		down_gap = st.duty - st.goal;
		waited   = '0;
		held     = '0;

		case (prsr_pkg::op_t'(opcode))
			prsr_pkg::OP_TICK: begin
				// ramp toward the goal without overshoot
				if (st.duty < st.goal) begin
					nx.duty = (up_sum > {1'b0, st.goal}) ? st.goal : up_sum[prsr_pkg::DUTY_W-1:0];
				end else if (st.duty > st.goal) begin
					nx.duty = (down_gap < st.step) ? st.goal : st.duty - st.step;
				end
				nx.ticks = st.ticks + 1'b1;
				if (nx.ticks >= cfg.watchdog) begin
					nx.goal = '0;
					nx.duty = '0;
				end
				advance = 1'b1;
			end
			prsr_pkg::OP_SET: begin
				if (idle) begin
					nx.dir  = direction;
					nx.goal = prsr_pkg::clamp_target(target_pwm);
				end
			end
			prsr_pkg::OP_REV: begin
				if (idle) begin
					nx.pend_dir    = direction;
					nx.pend_goal   = prsr_pkg::clamp_target(target_pwm);
					nx.phase_start = st.ticks;
					nx.step        = cfg.down_step;
					nx.goal        = '0;
					nx.phase       = prsr_pkg::PH_DOWN;
					advance        = 1'b1;
				end
			end
			default: begin
				if (idle) begin
					nx.goal = '0;
				end
			end
		endcase

		// reversal sequencing, ramp down may fall straight through hold
		if (advance && nx.phase == prsr_pkg::PH_DOWN) begin
			waited = nx.ticks - nx.phase_start;
			if (nx.duty == '0 || waited >= cfg.rev_timeout) begin
				nx.phase       = prsr_pkg::PH_HOLD;
				nx.phase_start = nx.ticks;
			end
		end
		if (advance && nx.phase == prsr_pkg::PH_HOLD) begin
			held = nx.ticks - nx.phase_start;
			if (held >= cfg.rev_hold) begin
				nx.step  = cfg.up_step;
				nx.dir   = nx.pend_dir;
				nx.goal  = nx.pend_goal;
				nx.phase = prsr_pkg::PH_IDLE;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/pwm_ramp_with_safe_reversal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_ramp_with_safe_reversal
// pwm duty slew limiter with watchdog and safe direction reversal
// ----------------------------------------------------------------------------
// One request per clock: each accepted request (tick, set target, safe
// reversal or brake) updates the controller state in a single combinational
// pass and its result (duty, direction, target, phase, watchdog flag, tick
// count) is valid on the next cycle, so throughput is one request per
// cycle while the result side keeps up. The state registers double as the
// result register; in_ready stays high while the pending result is being
// taken. The configuration port is always ready; writing ramp_step also
// reloads the active step. Write configuration only while no result is
// outstanding.
`default_nettype none
`include "assert_macros.svh"

module pwm_ramp_with_safe_reversal (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// config write channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [prsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [prsr_pkg::CFG_DATA_W-1:0]     cfg_data,
	// request channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [1:0]                          opcode,
	input  wire logic                                direction,
	input  wire logic signed [15:0]                  target_pwm,
	// result channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [prsr_pkg::DUTY_W-1:0]              pwm_duty,
	output logic                                     direction_out,
	output logic [prsr_pkg::DUTY_W-1:0]              target_now,
	output logic [1:0]                               phase,
	output logic                                     watchdog_expired,
	output logic [prsr_pkg::TICK_W-1:0]              tick_count
);

	prsr_pkg::cfg_t   cfg;
	prsr_pkg::state_t st_q;
	prsr_pkg::state_t st_nx;
	prsr_pkg::state_t st_d;
	logic             ramp_load;
	logic             accept;
	logic             out_valid_q;
	logic             wd_q;
	logic             tick_accept;
	logic             in_rev;

	// config registers
	assign cfg_ready = 1'b1;

	prsr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cfg_valid && cfg_ready),
		.wr_idx    (cfg_index),
		.wr_data   (cfg_data),
		.cfg       (cfg),
		.ramp_load (ramp_load)
	);

	// next state for the request at the input
	prsr_step_logic u_step (
		.st         (st_q),
		.cfg        (cfg),
		.opcode     (opcode),
		.direction  (direction),
		.target_pwm (target_pwm),
		.nx         (st_nx)
	);

	// a new request may enter while the current result is taken
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// state update: accepted request, then the step reload on a ramp_step write
	always_comb begin
		st_d = st_q;
		if (accept) begin
			st_d = st_nx;
		end
		// ramp step write reloads the active step, even mid reversal
		if (ramp_load) begin
			st_d.step = cfg_data[prsr_pkg::DUTY_W-1:0];
		end
	end

	// controller state, also the visible result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.duty        <= '0;
			st_q.goal        <= '0;
			st_q.dir         <= 1'b0;
			st_q.step        <= prsr_pkg::RAMP_STEP_RST;
			st_q.ticks       <= '0;
			st_q.phase       <= prsr_pkg::PH_IDLE;
			st_q.phase_start <= '0;
			st_q.pend_dir    <= 1'b0;
			st_q.pend_goal   <= '0;
			wd_q             <= 1'b0;
		end else begin
			st_q <= st_d;
			if (accept) begin
				wd_q <= (st_nx.ticks >= cfg.watchdog);
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign pwm_duty         = st_q.duty;
	assign direction_out    = st_q.dir;
	assign target_now       = st_q.goal;
	assign phase            = st_q.phase;
	assign watchdog_expired = wd_q;
	assign tick_count       = st_q.ticks;

	assign tick_accept = accept && (opcode == prsr_pkg::OP_TICK);
	assign in_rev      = (st_q.phase != prsr_pkg::PH_IDLE);

	// an accepted request always produces a result next cycle
	`PRSR_ASSERT_NEXT(a_result_follows, accept, out_valid, "no result after request")
	// tick counter only moves on an accepted tick
	`PRSR_ASSERT_NEXT(a_ticks_on_tick_only, !tick_accept, $stable(st_q.ticks), "stray tick")
	// a tick past the watchdog limit leaves the duty at zero
	`PRSR_ASSERT_NEXT(a_watchdog_zero, tick_accept, !wd_q || st_q.duty == '0, "duty past limit")
	// direction holds for as long as a reversal stays in progress
	`PRSR_ASSERT(a_dir_held_in_rev, in_rev ##1 in_rev |-> $stable(st_q.dir), "dir moved in reversal")

endmodule

`default_nettype wire
